// ----- hw/rtl/line_pixel_generator_top_assert.svh -----
// Assertion macros shared by the line pixel generator.
`ifndef LINE_PIXEL_GENERATOR_TOP_ASSERT_SVH
`define LINE_PIXEL_GENERATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line pixel generator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line pixel generator assertion failed");

`endif

// ----- hw/rtl/lpg_pkg.sv -----
package lpg_pkg;

  // Width of the coordinate fields on the ports.
  localparam int COORD_W = 16;
  // Default number of coordinate bits actually used.
  localparam int COORD_BITS_DEF = 16;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_POS  = 2'd1;
  localparam logic [1:0] DIR_NEG  = 2'd3;

  typedef struct packed {
    logic               operation;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic               last;
  } out_item_t;

  // Status of the stepping core, watched by the top level.
  typedef struct packed {
    logic active;
    logic emit;
    logic emit_last;
  } core_status_t;

endpackage

// ----- hw/rtl/lpg_in_reg.sv -----
module lpg_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lpg_pkg::in_item_t in_data,
  input  logic              take,
  output logic              buf_valid,
  output lpg_pkg::in_item_t buf_data
);

  logic              buf_valid_r;
  logic              buf_valid_nxt;
  lpg_pkg::in_item_t buf_data_r;

  // A new item can enter when the register is empty or is being drained.
  assign in_ready      = !buf_valid_r || take;
  assign buf_valid_nxt = (in_valid && in_ready) || (buf_valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
    end else begin
      buf_valid_r <= buf_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      buf_data_r <= in_data;
    end
  end

  assign buf_valid = buf_valid_r;
  assign buf_data  = buf_data_r;

endmodule

// ----- hw/rtl/lpg_core.sv -----
module lpg_core #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  buf_valid,
  input  lpg_pkg::in_item_t     buf_data,
  output logic                  take,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lpg_pkg::out_item_t    out_data,
  output lpg_pkg::core_status_t status
);

  localparam int EB = COORD_BITS + 1;

  logic [COORD_BITS-1:0] cur_x_r, cur_y_r, cur_x_nxt, cur_y_nxt;
  logic [EB-1:0]         err_x_r, err_y_r, err_x_nxt, err_y_nxt;
  logic [COORD_BITS-1:0] adx_r, ady_r, adx_nxt, ady_nxt;
  logic [1:0]            dir_x_r, dir_y_r, dir_x_nxt, dir_y_nxt;
  logic [COORD_BITS-1:0] dist_r, dist_nxt;
  logic [EB-1:0]         left_r, left_nxt;
  logic                  active_r, active_nxt;
  logic                  out_valid_r, out_valid_nxt;
  lpg_pkg::out_item_t    out_data_r, out_data_nxt;

  logic [COORD_BITS-1:0] sx, sy, ex, ey;
  logic [EB-1:0]         sum_x, sum_y;
  logic                  move_x, move_y;
  logic                  emit;
  logic                  is_last;

  // The item in the input register is consumed once the result slot is free.
  assign take = buf_valid && (!out_valid_r || out_ready);
  assign emit = take && (buf_data.operation == lpg_pkg::OP_STEP) && active_r;

  assign sx = buf_data.start_x[COORD_BITS-1:0];
  assign sy = buf_data.start_y[COORD_BITS-1:0];
  assign ex = buf_data.end_x[COORD_BITS-1:0];
  assign ey = buf_data.end_y[COORD_BITS-1:0];

  // The error terms never exceed the distance, so each sum fits in EB bits.
  assign sum_x   = err_x_r + {1'b0, adx_r};
  assign sum_y   = err_y_r + {1'b0, ady_r};
  assign move_x  = sum_x > {1'b0, dist_r};
  assign move_y  = sum_y > {1'b0, dist_r};
  assign is_last = left_r == EB'(1);

  function automatic logic [COORD_BITS-1:0] move_axis(
    input logic [COORD_BITS-1:0] pos,
    input logic [1:0]            dir
  );
    logic [COORD_BITS-1:0] res;
    res = pos;
    if (dir == lpg_pkg::DIR_POS) begin
      res = pos + COORD_BITS'(1);
    end else if (dir == lpg_pkg::DIR_NEG) begin
      res = pos - COORD_BITS'(1);
    end
    return res;
  endfunction

  always_comb begin
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    err_x_nxt  = err_x_r;
    err_y_nxt  = err_y_r;
    adx_nxt    = adx_r;
    ady_nxt    = ady_r;
    dir_x_nxt  = dir_x_r;
    dir_y_nxt  = dir_y_r;
    dist_nxt   = dist_r;
    left_nxt   = left_r;
    active_nxt = active_r;

    if (take && (buf_data.operation == lpg_pkg::OP_START)) begin
      priority if (ex > sx) begin
        adx_nxt   = ex - sx;
        dir_x_nxt = lpg_pkg::DIR_POS;
      end else if (ex == sx) begin
        adx_nxt   = '0;
        dir_x_nxt = lpg_pkg::DIR_NONE;
      end else begin
        adx_nxt   = sx - ex;
        dir_x_nxt = lpg_pkg::DIR_NEG;
      end
      priority if (ey > sy) begin
        ady_nxt   = ey - sy;
        dir_y_nxt = lpg_pkg::DIR_POS;
      end else if (ey == sy) begin
        ady_nxt   = '0;
        dir_y_nxt = lpg_pkg::DIR_NONE;
      end else begin
        ady_nxt   = sy - ey;
        dir_y_nxt = lpg_pkg::DIR_NEG;
      end
      dist_nxt   = (adx_nxt > ady_nxt) ? adx_nxt : ady_nxt;
      cur_x_nxt  = sx;
      cur_y_nxt  = sy;
      err_x_nxt  = '0;
      err_y_nxt  = '0;
      left_nxt   = {1'b0, dist_nxt} + EB'(2);
      active_nxt = 1'b1;
    end else if (emit) begin
      err_x_nxt  = move_x ? (sum_x - {1'b0, dist_r}) : sum_x;
      err_y_nxt  = move_y ? (sum_y - {1'b0, dist_r}) : sum_y;
      cur_x_nxt  = move_x ? move_axis(cur_x_r, dir_x_r) : cur_x_r;
      cur_y_nxt  = move_y ? move_axis(cur_y_r, dir_y_r) : cur_y_r;
      left_nxt   = left_r - EB'(1);
      active_nxt = !is_last;
    end
  end

  always_comb begin
    out_data_nxt         = out_data_r;
    out_data_nxt.pixel_x = lpg_pkg::COORD_W'(cur_x_r);
    out_data_nxt.pixel_y = lpg_pkg::COORD_W'(cur_y_r);
    out_data_nxt.last    = is_last;
  end

  assign out_valid_nxt = emit || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      err_x_r     <= '0;
      err_y_r     <= '0;
      adx_r       <= '0;
      ady_r       <= '0;
      dir_x_r     <= lpg_pkg::DIR_NONE;
      dir_y_r     <= lpg_pkg::DIR_NONE;
      dist_r      <= '0;
      left_r      <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      err_x_r     <= err_x_nxt;
      err_y_r     <= err_y_nxt;
      adx_r       <= adx_nxt;
      ady_r       <= ady_nxt;
      dir_x_r     <= dir_x_nxt;
      dir_y_r     <= dir_y_nxt;
      dist_r      <= dist_nxt;
      left_r      <= left_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;
  assign status.active    = active_r;
  assign status.emit      = emit;
  assign status.emit_last = is_last;

endmodule

// ----- hw/rtl/line_pixel_generator_top.sv -----
// Channel   Ports                          Moves
// input     in_valid, in_ready, in_data    start or step command with endpoints
// output    out_valid, out_ready, out_data one pixel coordinate with last flag
//
// One item per cycle while the result is not stalled: an item waits in the input
// register, then the stepping core updates the line state and loads the result register.
// Synchronous active-low reset clears the line state; no line is active after it.
// A stalled result holds the core; the input register still takes one more item.
`include "line_pixel_generator_top_assert.svh"

module line_pixel_generator_top #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lpg_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lpg_pkg::out_item_t out_data
);

  logic                  buf_valid;
  lpg_pkg::in_item_t     buf_data;
  logic                  take;
  lpg_pkg::core_status_t status;

  lpg_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .take      (take),
    .buf_valid (buf_valid),
    .buf_data  (buf_data)
  );

  lpg_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .buf_valid (buf_valid),
    .buf_data  (buf_data),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .status    (status)
  );

  // A pixel is only produced for a running line.
  `LPG_ASSERT_SAME(a_emit_active, clk, rst_n, status.emit, status.active)
  // The final pixel ends the line.
  `LPG_ASSERT_NEXT(a_last_ends, clk, rst_n, status.emit && status.emit_last, !status.active)
  // Input is refused only while a buffered item waits.
  `LPG_ASSERT_SAME(a_ready_buf, clk, rst_n, !in_ready, buf_valid)
  // A produced pixel appears in the result register on the next cycle.
  `LPG_ASSERT_NEXT(a_emit_out, clk, rst_n, status.emit, out_valid)

endmodule
